// File: src/assert_macros.svh
// shared assertion macros, clocked on clk_i; PVFU_ASSERT uses rst_ni as the disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PVFU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("pvfu check failed");
`define PVFU_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("pvfu reset check failed");
`else
`define PVFU_ASSERT(lbl, prop)
`define PVFU_ASSERT_RST(lbl, prop)
`endif
`endif

// File: src/pvfu_pkg.sv
package pvfu_pkg;

  typedef logic [2:0] fmt_t;
  localparam fmt_t FMT_R5G5B5A1    = 3'd0;
  localparam fmt_t FMT_R5G6B5      = 3'd1;
  localparam fmt_t FMT_R4G4B4A4    = 3'd2;
  localparam fmt_t FMT_R10G10B10A2 = 3'd3;
  localparam fmt_t FMT_R11G11B10   = 3'd4;

  typedef logic [2:0] ctype_t;
  localparam ctype_t CT_UINT    = 3'd0;
  localparam ctype_t CT_USCALED = 3'd1;
  localparam ctype_t CT_SINT    = 3'd2;
  localparam ctype_t CT_SSCALED = 3'd3;
  localparam ctype_t CT_SNORM   = 3'd4;
  localparam ctype_t CT_UNORM   = 3'd5;

  localparam logic [1:0] KIND_FLOAT = 2'd0;
  localparam logic [1:0] KIND_UINT  = 2'd1;
  localparam logic [1:0] KIND_SINT  = 2'd2;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTYPE  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BGRA   = 8'd2;

  localparam int QDEPTH = 2;

  localparam logic [31:0] FP_ONE = 32'h3f800000;
  localparam logic [31:0] FP_INF = 32'h7f800000;
  localparam logic [31:0] FP_QNAN = 32'h7fc00000;

  typedef struct packed {
    logic [31:0] word;
    fmt_t        fmt;
    ctype_t      ctype;
    logic        swap;
    logic [1:0]  last_idx;
  } entry_t;

  typedef enum logic [2:0] {
    OP_RAW_U,
    OP_RAW_S,
    OP_INT,
    OP_RECIP,
    OP_SMALL,
    OP_CONST
  } op_e;

  // index of the top set bit of a 10-bit value
  function automatic logic [3:0] msb10(logic [9:0] n);
    logic [3:0] p;
    p = '0;
    for (int i = 0; i < 10; i++) begin
      if (n[i]) p = 4'(i);
    end
    return p;
  endfunction

  // binary expansion of n / (2^b - 1) repeats n with period b
  function automatic logic [39:0] rep_pattern(logic [9:0] n, logic [3:0] b);
    logic [39:0] s;
    s = '0;
    case (b)
      4'd2: for (int j = 0; j < 40; j++) s[39-j] = n[1-(j%2)];
      4'd4: for (int j = 0; j < 40; j++) s[39-j] = n[3-(j%4)];
      4'd5: for (int j = 0; j < 40; j++) s[39-j] = n[4-(j%5)];
      4'd6: for (int j = 0; j < 40; j++) s[39-j] = n[5-(j%6)];
      4'd9: for (int j = 0; j < 40; j++) s[39-j] = n[8-(j%9)];
      default: for (int j = 0; j < 40; j++) s[39-j] = n[9-(j%10)];
    endcase
    return s;
  endfunction

  // float32 of +-n / (2^b - 1), n <= 2^b - 1; never a tie, so guard bit rounds
  function automatic logic [31:0] recip_bits(logic [9:0] n, logic [3:0] b, logic neg);
    logic [9:0]  mask;
    logic [3:0]  lz;
    logic [39:0] s;
    logic [24:0] m;
    mask = 10'((11'd1 << b) - 11'd1);
    lz   = 4'(b - 4'd1 - msb10(n));
    s    = rep_pattern(n, b) << lz;
    m    = {1'b0, s[39:16]} + 25'(s[15]);
    if (n == '0) return '0;
    if (n == mask) return {neg, FP_ONE[30:0]};
    return {neg, 8'(8'd126 - {4'd0, lz}), m[22:0]};
  endfunction

  function automatic logic [31:0] int_bits(logic [9:0] n, logic neg);
    logic [3:0]  p;
    logic [32:0] t;
    p = msb10(n);
    t = 33'(n) << (5'd23 - {1'b0, p});
    if (n == '0) return '0;
    return {neg, 8'(8'd127 + {4'd0, p}), t[22:0]};
  endfunction

  // unsigned small float, 5-bit exponent, mbits mantissa
  function automatic logic [31:0] small_bits(logic [4:0] e, logic [5:0] m, logic [2:0] mbits);
    logic [3:0]  p;
    logic [29:0] t;
    logic [29:0] u;
    p = msb10({4'd0, m});
    t = 30'(m ^ 6'(6'd1 << p)) << (5'd23 - {1'b0, p});
    u = 30'(m) << (5'd23 - {2'b0, mbits});
    if (e == '0 && m == '0) return '0;
    if (e == 5'd31) return (m == '0) ? FP_INF : FP_QNAN;
    if (e != '0) return {1'b0, 8'({3'd0, e} + 8'd112), u[22:0]};
    return {1'b0, 8'(8'd113 + {4'd0, p} - {5'd0, mbits}), t[22:0]};
  endfunction

endpackage

// File: src/pvfu_if.sv
interface pvfu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_word;
  modport source (output valid, output packed_word, input ready);
  modport sink (input valid, input packed_word, output ready);
endinterface

interface pvfu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] component_value;
  logic [1:0]  value_kind;
  logic [1:0]  component_index;
  logic        last_component;
  modport source (output valid, output component_value, output value_kind,
                  output component_index, output last_component, input ready);
  modport sink (input valid, input component_value, input value_kind,
                input component_index, input last_component, output ready);
endinterface

interface pvfu_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/pvfu_front.sv
module pvfu_front import pvfu_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  pvfu_cfg_if.sink cfg_i,
  pvfu_in_if.sink  in_i,
  input  logic   q_full_i,
  output logic   push_o,
  output entry_t entry_o
);

  fmt_t   fmt_q;
  ctype_t ctype_q;
  logic   bgra_q;
  logic   wr;

  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FMT_R5G5B5A1;
      ctype_q <= CT_UNORM;
      bgra_q  <= 1'b0;
    end else if (wr) begin
      if (cfg_i.index == REG_FORMAT) fmt_q <= cfg_i.data[2:0];
      if (cfg_i.index == REG_CTYPE) ctype_q <= cfg_i.data[2:0];
      if (cfg_i.index == REG_BGRA) bgra_q <= cfg_i.data[0];
    end
  end

  assign in_i.ready = !q_full_i;
  // unknown formats are taken and dropped
  assign push_o = in_i.valid && in_i.ready && (fmt_q <= FMT_R11G11B10);

  always_comb begin
    entry_o.word     = in_i.packed_word;
    entry_o.fmt      = fmt_q;
    entry_o.ctype    = ctype_q;
    entry_o.swap     = bgra_q && (fmt_q != FMT_R11G11B10);
    entry_o.last_idx = (fmt_q == FMT_R5G6B5 || fmt_q == FMT_R11G11B10) ? 2'd2 : 2'd3;
  end

endmodule

// File: src/pvfu_queue.sv
`include "assert_macros.svh"
module pvfu_queue import pvfu_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int PtrW = $clog2(QDEPTH);
  localparam int CntW = $clog2(QDEPTH + 1);

  entry_t            mem_q [QDEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? PtrW'((32'(wr_q) + 1) % QDEPTH) : wr_q;
    rd_d  = pop_i ? PtrW'((32'(rd_q) + 1) % QDEPTH) : rd_q;
    cnt_d = CntW'(cnt_q + CntW'(push_i) - CntW'(pop_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  `PVFU_ASSERT(a_no_overflow, push_i |-> (!full_o || pop_i))
  `PVFU_ASSERT(a_no_underflow, pop_i |-> valid_o)
  `PVFU_ASSERT(a_cnt_range, cnt_q <= CntW'(QDEPTH))
  `PVFU_ASSERT_RST(a_empty_out_of_reset, !rst_ni |=> cnt_q == '0)

endmodule

// File: src/pvfu_back.sv
`include "assert_macros.svh"
module pvfu_back import pvfu_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   q_valid_i,
  input  entry_t q_entry_i,
  output logic   q_pop_o,
  pvfu_out_if.source out_o
);

  entry_t      entry_q;
  logic        busy_q, busy_d;
  logic [1:0]  idx_q, idx_d;
  logic        ov_q, ov_d;
  logic [31:0] oval_q;
  logic [1:0]  okind_q, oidx_q;
  logic        olast_q;

  logic        adv, fire, last;
  logic [1:0]  c;
  op_e         op;
  logic [9:0]  raw, mag, n;
  logic [3:0]  b;
  logic        neg, alpha;
  logic [4:0]  se;
  logic [5:0]  sm;
  logic [2:0]  mbits;
  logic [31:0] cval, val;
  logic [1:0]  kind;
  logic [31:0] w;

  assign adv  = !ov_q || out_o.ready;
  assign fire = busy_q && adv;
  assign last = (idx_q == entry_q.last_idx);
  assign q_pop_o = q_valid_i && (!busy_q || (fire && last));

  // decode the source field of this component
  always_comb begin
    w     = entry_q.word;
    c     = idx_q;
    if (entry_q.swap && idx_q == 2'd0) c = 2'd2;
    if (entry_q.swap && idx_q == 2'd2) c = 2'd0;
    op    = OP_RECIP;
    n     = '0;
    b     = 4'd10;
    neg   = 1'b0;
    se    = '0;
    sm    = '0;
    mbits = 3'd6;
    cval  = '0;
    alpha = (c == 2'd3);
    raw   = alpha ? {8'd0, w[31:30]} : w[10*c +: 10];
    neg   = 1'b0;
    mag   = raw;
    unique case (entry_q.fmt)
      FMT_R5G5B5A1: begin
        if (alpha) begin
          op   = OP_CONST;
          cval = w[15] ? FP_ONE : '0;
        end else begin
          n = {5'd0, w[5*c +: 5]};
          b = 4'd5;
        end
      end
      FMT_R5G6B5: begin
        unique case (c)
          2'd0: begin n = {5'd0, w[4:0]}; b = 4'd5; end
          2'd1: begin n = {4'd0, w[10:5]}; b = 4'd6; end
          default: begin n = {5'd0, w[15:11]}; b = 4'd5; end
        endcase
      end
      FMT_R4G4B4A4: begin
        n = {6'd0, w[4*c +: 4]};
        b = 4'd4;
      end
      FMT_R10G10B10A2: begin
        if (entry_q.ctype == CT_SSCALED || entry_q.ctype == CT_SNORM) begin
          neg = alpha ? raw[1] : raw[9];
          if (neg) mag = alpha ? {8'd0, 2'(-raw[1:0])} : 10'(-raw);
        end
        case (entry_q.ctype)
          CT_UINT: op = OP_RAW_U;
          CT_SINT: op = OP_RAW_S;
          CT_USCALED: begin op = OP_INT; n = raw; end
          CT_SSCALED: begin op = OP_INT; n = mag; end
          CT_SNORM: begin
            if (alpha) begin
              op = OP_INT;
              n  = (mag == 10'd2) ? 10'd1 : mag;
            end else begin
              n = (mag == 10'd512) ? 10'd511 : mag;
              b = 4'd9;
            end
          end
          default: begin
            n = raw;
            b = alpha ? 4'd2 : 4'd10;
          end
        endcase
      end
      default: begin
        op = OP_SMALL;
        unique case (c)
          2'd0: begin se = w[10:6]; sm = w[5:0]; end
          2'd1: begin se = w[21:17]; sm = w[16:11]; end
          default: begin se = w[31:27]; sm = {1'b0, w[26:22]}; mbits = 3'd5; end
        endcase
      end
    endcase
  end

  // one shared conversion unit
  always_comb begin
    kind = KIND_FLOAT;
    unique case (op)
      OP_RAW_U: begin val = {22'd0, raw}; kind = KIND_UINT; end
      OP_RAW_S: begin
        val  = alpha ? {{30{raw[1]}}, raw[1:0]} : {{22{raw[9]}}, raw};
        kind = KIND_SINT;
      end
      OP_INT:   val = int_bits(n, neg);
      OP_RECIP: val = recip_bits(n, b, neg);
      OP_SMALL: val = small_bits(se, sm, mbits);
      default:  val = cval;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (fire) begin
      idx_d = idx_q + 2'd1;
      if (last) busy_d = 1'b0;
    end
    if (q_pop_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
    ov_d = fire ? 1'b1 : (out_o.ready ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) entry_q <= q_entry_i;
    if (fire) begin
      oval_q  <= val;
      okind_q <= kind;
      oidx_q  <= idx_q;
      olast_q <= last;
    end
  end

  assign out_o.valid           = ov_q;
  assign out_o.component_value = oval_q;
  assign out_o.value_kind      = okind_q;
  assign out_o.component_index = oidx_q;
  assign out_o.last_component  = olast_q;

  `PVFU_ASSERT(a_idx_in_range, busy_q |-> idx_q <= entry_q.last_idx)
  `PVFU_ASSERT(a_last_resets_idx, (fire && last && !q_pop_o) |=> !busy_q)
  `PVFU_ASSERT(a_kind_legal, ov_q |-> okind_q != 2'd3)

endmodule

// File: src/packed_vertex_format_unpacker.sv
// words pass the queue and entry_q; components leave through the output registers
// throughput: one component per cycle while out_o.ready allows, set by the single output channel;
// four components per word for four-component formats, 3 for r5g6b5 and r11g11b10
// a 2-entry queue sits between input decode and the component sequencer
// reset: format r5g5b5a1, component type unorm, no bgra swap; queue and output empty
module packed_vertex_format_unpacker import pvfu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  pvfu_cfg_if.sink   cfg_i,
  pvfu_in_if.sink    in_i,
  pvfu_out_if.source out_o
);

  logic   push, full, pop, qvalid;
  entry_t push_entry, head_entry;

  pvfu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .in_i     (in_i),
    .q_full_i (full),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  pvfu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (qvalid),
    .entry_o (head_entry)
  );

  pvfu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (qvalid),
    .q_entry_i (head_entry),
    .q_pop_o   (pop),
    .out_o     (out_o)
  );

endmodule
